// ----- rtl/lbft_pkg.sv -----
// Shared types and constants for the learning bridge forwarding table.
package lbft_pkg;

    localparam int ADDR_W    = 48;
    localparam int PORT_W    = 3;
    localparam int ACT_W     = 2;
    localparam int ENTRY_W   = ADDR_W + PORT_W;
    localparam int S_TDATA_W = 104;  // 99 payload bits padded to whole bytes
    localparam int M_TDATA_W = 8;    // 7 payload bits padded to whole bytes

    localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DISCARD = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEARN,
        ST_DONE
    } state_t;

    // sequencer controls toward the datapath
    typedef struct packed {
        logic in_ready;
        logic cmp_valid;
        logic learn_step;
        logic finish_step;
    } ctl_t;

    // compare unit results
    typedef struct packed {
        logic src_hit;
        logic dst_hit;
        logic self_loop;
    } cmp_t;

endpackage

// ----- rtl/lbft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lbft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lbft_cmp.sv -----
// Shared address compare unit: one table entry against source and destination.
module lbft_cmp
    import lbft_pkg::*;
(
    input  logic [ENTRY_W-1:0] entry,
    input  logic [ADDR_W-1:0]  src_address,
    input  logic [ADDR_W-1:0]  dst_address,
    output cmp_t               hit
);

    logic [ADDR_W-1:0] entry_address;

    assign entry_address = entry[ENTRY_W-1:PORT_W];

    always_comb begin
        hit.src_hit   = (entry_address == src_address);
        hit.dst_hit   = (entry_address == dst_address);
        hit.self_loop = (src_address == dst_address);
    end

endmodule

// ----- rtl/lbft_ctrl.sv -----
// Scan sequencer: walks filled entries, one learn step, hand-off; skip: hand-off only.
module lbft_ctrl
    import lbft_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         skip,
    input  logic [$clog2(ENTRIES+1)-1:0] fill_count,
    input  logic                         out_free,
    output logic                         rd_en,
    output logic [$clog2(ENTRIES)-1:0]   rd_addr,
    output logic [$clog2(ENTRIES)-1:0]   cmp_idx,
    output ctl_t                         ctl
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          pend_reg;
    logic [AW-1:0] pend_idx_reg;
    logic          issue;

    assign issue = (state_reg == ST_SCAN) && (scan_cnt_reg < fill_count);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = skip ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue) begin
                    state_next = ST_LEARN;
                end
            end
            ST_LEARN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        ctl.in_ready    = (state_reg == ST_IDLE);
        ctl.cmp_valid   = pend_reg;
        ctl.learn_step  = (state_reg == ST_LEARN);
        ctl.finish_step = (state_reg == ST_DONE) && out_free;
        rd_en           = issue;
        rd_addr         = scan_cnt_reg[AW-1:0];
        cmp_idx         = pend_idx_reg;
    end

    always_comb begin
        scan_cnt_next = scan_cnt_reg;
        if (state_reg == ST_IDLE) begin
            scan_cnt_next = '0;
        end else if (issue) begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            pend_reg     <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            pend_idx_reg <= scan_cnt_reg[AW-1:0];
        end
    end

endmodule

// ----- rtl/learning_bridge_forward_table.sv -----
// Learning bridge forwarding table: source learning and destination lookup per frame header.
// Sequence: after a request is accepted the scan reads each filled entry, then the learn
//   step writes the table; a bad ingress port skips scan and learn. The result is registered
//   once the output is free, and a new request is taken only after the last result is handed
//   off; the scan walks the single read port of the entry RAM one entry per cycle.
// Reset: aresetn (sync, active low) empties the table by clearing the fill count;
//   RAM contents are not cleared, entries past the fill count are never read.
module learning_bridge_forward_table
    import lbft_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int PORTS   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [47:0] src_address, [95:48] dst_address, [98:96] ingress_port, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] action, [4:2] out_port, [5] learned, [6] table_full, [7] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // request fields
    logic [ADDR_W-1:0] s_src;
    logic [ADDR_W-1:0] s_dst;
    logic [PORT_W-1:0] s_port;
    logic              accept;
    logic              bad_port;

    assign s_src    = s_tdata[ADDR_W-1:0];
    assign s_dst    = s_tdata[2*ADDR_W-1:ADDR_W];
    assign s_port   = s_tdata[2*ADDR_W+PORT_W-1:2*ADDR_W];
    assign accept   = s_tvalid && s_tready;
    // ports at or above PORTS do not exist on this bridge
    assign bad_port = ({{(32-PORT_W){1'b0}}, s_port} >= 32'(PORTS));

    // captured request
    logic [ADDR_W-1:0] src_reg;
    logic [ADDR_W-1:0] dst_reg;
    logic [PORT_W-1:0] port_reg;

    // scan results
    logic              src_hit_reg;
    logic [AW-1:0]     src_idx_reg;
    logic [PORT_W-1:0] src_port_reg;
    logic              dst_hit_reg;
    logic [PORT_W-1:0] dst_port_reg;

    // table fill: entries [0, fill) are valid, learning always takes the lowest free slot
    logic [CW-1:0]     fill_reg, fill_next;

    // pending result
    logic [ACT_W-1:0]  res_action_reg, res_action_next;
    logic [PORT_W-1:0] res_port_reg, res_port_next;
    logic              res_learned_reg, res_learned_next;
    logic              res_full_reg, res_full_next;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    ctl_t          ctl;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] cmp_idx;

    lbft_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .skip       (bad_port),
        .fill_count (fill_reg),
        .out_free   (out_free),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .cmp_idx    (cmp_idx),
        .ctl        (ctl)
    );

    // entry store: {address, port}
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    lbft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // shared compare unit, fed one entry per scan cycle
    cmp_t hit;

    lbft_cmp u_cmp (
        .entry       (ram_rdata),
        .src_address (src_reg),
        .dst_address (dst_reg),
        .hit         (hit)
    );

    assign s_tready = ctl.in_ready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            src_reg  <= s_src;
            dst_reg  <= s_dst;
            port_reg <= s_port;
        end
    end

    // first match wins; addresses are unique in the table anyway
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_hit_reg <= 1'b0;
            dst_hit_reg <= 1'b0;
        end else if (accept) begin
            src_hit_reg <= 1'b0;
            dst_hit_reg <= 1'b0;
        end else if (ctl.cmp_valid) begin
            if (hit.src_hit && !src_hit_reg) begin
                src_hit_reg <= 1'b1;
            end
            if (hit.dst_hit && !dst_hit_reg) begin
                dst_hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.cmp_valid && hit.src_hit && !src_hit_reg) begin
            src_idx_reg  <= cmp_idx;
            src_port_reg <= ram_rdata[PORT_W-1:0];
        end
        if (ctl.cmp_valid && hit.dst_hit && !dst_hit_reg) begin
            dst_port_reg <= ram_rdata[PORT_W-1:0];
        end
    end

    // learn step and forwarding decision
    logic stored_src;

    always_comb begin
        ram_we           = 1'b0;
        ram_waddr        = src_idx_reg;
        ram_wdata        = {src_reg, port_reg};
        fill_next        = fill_reg;
        stored_src       = 1'b1;
        res_action_next  = res_action_reg;
        res_port_next    = res_port_reg;
        res_learned_next = res_learned_reg;
        res_full_next    = res_full_reg;

        if (accept && bad_port) begin
            res_action_next  = ACT_DISCARD;
            res_port_next    = '0;
            res_learned_next = 1'b0;
            res_full_next    = 1'b0;
        end else if (ctl.learn_step) begin
            res_learned_next = 1'b0;
            res_full_next    = 1'b0;
            if (src_hit_reg) begin
                // station moved: rewrite its port
                if (src_port_reg != port_reg) begin
                    ram_we           = 1'b1;
                    res_learned_next = 1'b1;
                end
            end else if (fill_reg < CW'(ENTRIES)) begin
                ram_we           = 1'b1;
                ram_waddr        = fill_reg[AW-1:0];
                fill_next        = fill_reg + 1'b1;
                res_learned_next = 1'b1;
            end else begin
                stored_src    = 1'b0;
                res_full_next = 1'b1;
            end

            // destination sees the table after learning; only the source entry can change
            res_port_next = '0;
            if (hit.self_loop) begin
                res_action_next = stored_src ? ACT_DISCARD : ACT_FLOOD;
            end else if (!dst_hit_reg) begin
                res_action_next = ACT_FLOOD;
            end else if (dst_port_reg == port_reg) begin
                res_action_next = ACT_DISCARD;
            end else begin
                res_action_next = ACT_FORWARD;
                res_port_next   = dst_port_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_action_reg  <= res_action_next;
        res_port_reg    <= res_port_next;
        res_learned_reg <= res_learned_next;
        res_full_reg    <= res_full_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.finish_step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.finish_step) begin
            m_tdata_reg <= {1'b0, res_full_reg, res_learned_reg, res_port_reg, res_action_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/lbft_checker.sv -----
// Port-level checks for the learning bridge forwarding table, bound to the top level.
module lbft_checker
    import lbft_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one request at a time: the scan occupies the block after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted during scan");

    // out_port only carries a port on forward
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ACT_FORWARD) |-> (m_tdata[4:2] == 3'd0))
        else $error("out_port set without forward");

    // a source is either learned or rejected for lack of room, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[5] && m_tdata[6]))
        else $error("learned and table_full together");

    // action code stays in range and pad bit is clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && !m_tdata[7])
        else $error("bad action code");

endmodule

bind learning_bridge_forward_table lbft_checker u_lbft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
